// ----- hw/rtl/tcde_pkg.sv -----
// ----------------------------------------------------------------------------
// tcde_pkg
// Shared types and constants of the tile cache with distance-based eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package tcde_pkg;

  // Operation carried by one request transaction.
  typedef enum logic [2:0] {
    KIND_LOOKUP = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_MOVE   = 3'd2,
    KIND_EVICT  = 3'd3,
    KIND_CLEAR  = 3'd4
  } tcde_kind_t;

  localparam int KIND_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int COUNT_BITS    = 5;
  localparam int TOTAL_BITS    = 32;
  localparam int RANGE_BITS    = 16;
  localparam int HYST_BITS     = 8;
  localparam int THR_BITS      = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CACHE_RANGE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS  = 2'd2;

  // Register values after reset.
  localparam logic [COUNT_BITS-1:0] MAX_ENTRIES_RST = 5'd16;
  localparam logic [RANGE_BITS-1:0] CACHE_RANGE_RST = 16'd2;
  localparam logic [HYST_BITS-1:0]  HYSTERESIS_RST  = 8'd1;

  // Tag that travels with each slot read through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } tcde_tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcde_if.sv -----
// ----------------------------------------------------------------------------
// tcde interfaces
// Valid/ready channels of the tile cache: request, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcde_req_if #(
  parameter int COORD_BITS = 16
);
  import tcde_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [KIND_BITS-1:0]         kind;
  logic signed [COORD_BITS-1:0] tile_x;
  logic signed [COORD_BITS-1:0] tile_y;

  modport source (output valid, kind, tile_x, tile_y, input ready);
  modport sink   (input valid, kind, tile_x, tile_y, output ready);
endinterface

interface tcde_rsp_if;
  import tcde_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [COUNT_BITS-1:0] evicted_now;
  logic [COUNT_BITS-1:0] occupancy;
  logic [TOTAL_BITS-1:0] hit_total;
  logic [TOTAL_BITS-1:0] miss_total;
  logic [TOTAL_BITS-1:0] load_total;
  logic [TOTAL_BITS-1:0] evict_total;

  modport source (output valid, hit, evicted_now, occupancy, hit_total, miss_total,
                  load_total, evict_total, input ready);
  modport sink   (input valid, hit, evicted_now, occupancy, hit_total, miss_total,
                  load_total, evict_total, output ready);
endinterface

interface tcde_cfg_if;
  import tcde_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcde_ram.sv -----
// ----------------------------------------------------------------------------
// tcde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// ----- hw/rtl/tcde_dist.sv -----
// ----------------------------------------------------------------------------
// tcde_dist
// Two-stage pipeline giving the Chebyshev distance of a slot from the current
// tile and whether the slot holds the request's tile.
// ----------------------------------------------------------------------------
`default_nettype none

module tcde_dist #(
  parameter int COORD_BITS = 16,
  parameter int IDX_BITS   = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tcde_pkg::tcde_tag_t          in_tag,
  input  wire logic [IDX_BITS-1:0]          in_idx,
  input  wire logic signed [COORD_BITS-1:0] slot_x,
  input  wire logic signed [COORD_BITS-1:0] slot_y,
  input  wire logic signed [COORD_BITS-1:0] here_x,
  input  wire logic signed [COORD_BITS-1:0] here_y,
  input  wire logic signed [COORD_BITS-1:0] tile_x,
  input  wire logic signed [COORD_BITS-1:0] tile_y,
  output tcde_pkg::tcde_tag_t               out_tag,
  output logic [IDX_BITS-1:0]               out_idx,
  output logic [COORD_BITS-1:0]             cheb_dist,
  output logic                              match
);
  import tcde_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic [DW-1:0]         dxa, dxb, dya, dyb;
  logic [COORD_BITS-1:0] absx, absy;
  logic [COORD_BITS-1:0] absx_q, absy_q;
  logic                  match_q;
  tcde_tag_t             tag_q;
  logic [IDX_BITS-1:0]   idx_q;

  // Both differences are formed at once; the non-negative one is the magnitude.
  assign dxa  = {slot_x[COORD_BITS-1], slot_x} - {here_x[COORD_BITS-1], here_x};
  assign dxb  = {here_x[COORD_BITS-1], here_x} - {slot_x[COORD_BITS-1], slot_x};
  assign dya  = {slot_y[COORD_BITS-1], slot_y} - {here_y[COORD_BITS-1], here_y};
  assign dyb  = {here_y[COORD_BITS-1], here_y} - {slot_y[COORD_BITS-1], slot_y};
  assign absx = dxa[DW-1] ? dxb[COORD_BITS-1:0] : dxa[COORD_BITS-1:0];
  assign absy = dya[DW-1] ? dyb[COORD_BITS-1:0] : dya[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q   <= '0;
      out_tag <= '0;
    end else begin
      tag_q   <= in_tag;
      out_tag <= tag_q;
    end
  end

  always_ff @(posedge clk) begin
    idx_q     <= in_idx;
    absx_q    <= absx;
    absy_q    <= absy;
    match_q   <= (slot_x == tile_x) && (slot_y == tile_y);
    out_idx   <= idx_q;
    cheb_dist <= (absx_q > absy_q) ? absx_q : absy_q;
    match     <= match_q;
  end
endmodule

`default_nettype wire

// ----- hw/rtl/tile_cache_distance_eviction_unit.sv -----
// ----------------------------------------------------------------------------
// tile_cache_distance_eviction_unit
// Tag table of 2-D tile coordinates with Chebyshev-distance replacement.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                                   | Ready
//   --------+-----------+-------------------------------------------+----------------
//   cfg     | in        | index, data                               | always high
//   req     | in        | kind, tile_x, tile_y                      | high when idle
//   rsp     | out       | hit, evicted_now, occupancy, four totals  | from the sink
//
// Every slot scan reads the coordinate RAM one entry per cycle and then drains
// the distance pipeline. Lookup, evict and a position update take one scan,
// clear takes no scan, and an insert that misses takes one match scan, one
// sweep scan and one further scan for every farthest eviction.
// Reset clears all slot valid bits at once, so there is no clearing pass.
// A result waits in the output register while the next request is accepted; the
// block stalls only when a second result is ready before the first was taken.
//
`default_nettype none

module tile_cache_distance_eviction_unit #(
  parameter int SLOTS      = 16,
  parameter int COORD_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  tcde_cfg_if.sink   cfg,
  tcde_req_if.sink   req,
  tcde_rsp_if.source rsp
);
  import tcde_pkg::*;

  localparam int IDX_BITS = $clog2(SLOTS);
  localparam int OCC_BITS = $clog2(SLOTS + 1);
  localparam int LIM_BITS = (OCC_BITS > COUNT_BITS) ? OCC_BITS : COUNT_BITS;
  localparam int CMP_BITS = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS;

  // Sequencer states. A scan issues every slot address and then drains the
  // distance pipeline; the state after it acts on what the scan gathered.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NEXT,
    S_CHECK,
    S_STORE,
    S_DONE
  } state_t;

  // What a scan is looking for.
  typedef enum logic [1:0] {
    P_MATCH,
    P_SWEEP,
    P_FAR
  } pass_t;

  state_t state;
  pass_t  pass;

  // Configuration registers.
  logic [COUNT_BITS-1:0] max_entries;
  logic [RANGE_BITS-1:0] cache_range;
  logic [HYST_BITS-1:0]  hysteresis;

  // Transaction being worked on.
  logic [KIND_BITS-1:0]         kind_q;
  logic signed [COORD_BITS-1:0] tx_q, ty_q;
  logic                         do_sweep;
  logic                         hit_q;
  logic [OCC_BITS-1:0]          removed;

  // Table state: valid bits in flops, coordinates in the RAM.
  logic [SLOTS-1:0]             slot_valid;
  logic [OCC_BITS-1:0]          occ;
  logic signed [COORD_BITS-1:0] here_x, here_y;

  logic [TOTAL_BITS-1:0] hit_counter, miss_counter, load_counter, evict_counter;

  // Scan issue side.
  logic                iss_on;
  logic [IDX_BITS-1:0] iss_idx;
  logic                iss_last;
  tcde_tag_t           s1_tag;
  logic [IDX_BITS-1:0] s1_idx;

  // Decision side, at the end of the distance pipeline.
  tcde_tag_t             d_tag;
  logic [IDX_BITS-1:0]   d_idx;
  logic [COORD_BITS-1:0] d_dist;
  logic                  d_match;

  // Gathered during scans.
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_idx;
  logic                  far_found;
  logic [IDX_BITS-1:0]   far_idx;
  logic [COORD_BITS-1:0] far_dist;

  logic [2*COORD_BITS-1:0] rd_data;
  logic                    ram_we;

  logic                v_cur;
  logic [THR_BITS-1:0] thr;
  logic                beyond;
  logic                farther;
  logic [LIM_BITS-1:0] max_ext;
  logic [LIM_BITS-1:0] limit;
  logic                need_far;
  logic                moved;

  logic                  rsp_valid;
  logic                  rsp_hit;
  logic [COUNT_BITS-1:0] rsp_evicted_now;
  logic [COUNT_BITS-1:0] rsp_occupancy;
  logic [TOTAL_BITS-1:0] rsp_hit_total, rsp_miss_total, rsp_load_total, rsp_evict_total;

  tcde_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (SLOTS)
  ) u_coord_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata ({tx_q, ty_q}),
    .raddr (iss_idx),
    .rdata (rd_data)
  );

  tcde_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_BITS   (IDX_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_tag    (s1_tag),
    .in_idx    (s1_idx),
    .slot_x    (rd_data[2*COORD_BITS-1:COORD_BITS]),
    .slot_y    (rd_data[COORD_BITS-1:0]),
    .here_x    (here_x),
    .here_y    (here_y),
    .tile_x    (tx_q),
    .tile_y    (ty_q),
    .out_tag   (d_tag),
    .out_idx   (d_idx),
    .cheb_dist (d_dist),
    .match     (d_match)
  );

  assign ram_we   = (state == S_STORE);
  assign iss_last = (iss_idx == IDX_BITS'(SLOTS - 1));

  // The valid bit is read when the slot reaches the decision stage; each slot is
  // decided once per scan, so it already reflects earlier removals.
  assign v_cur   = slot_valid[d_idx];
  assign thr     = THR_BITS'(cache_range) + THR_BITS'(hysteresis);
  assign beyond  = CMP_BITS'(d_dist) > CMP_BITS'(thr);
  assign farther = !far_found || (d_dist > far_dist);

  // A table limit above the slot count behaves as the slot count.
  assign max_ext  = LIM_BITS'(max_entries);
  assign limit    = (max_ext > LIM_BITS'(SLOTS)) ? LIM_BITS'(SLOTS) : max_ext;
  assign need_far = (occ != '0) && (LIM_BITS'(occ) >= limit);

  assign moved = (req.tile_x != here_x) || (req.tile_y != here_y);

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = rsp_hit;
  assign rsp.evicted_now = rsp_evicted_now;
  assign rsp.occupancy   = rsp_occupancy;
  assign rsp.hit_total   = rsp_hit_total;
  assign rsp.miss_total  = rsp_miss_total;
  assign rsp.load_total  = rsp_load_total;
  assign rsp.evict_total = rsp_evict_total;

  // The slot tag leaves the issue side together with the RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else begin
      s1_tag.valid <= iss_on;
      s1_tag.last  <= iss_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= iss_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pass          <= P_MATCH;
      max_entries   <= MAX_ENTRIES_RST;
      cache_range   <= CACHE_RANGE_RST;
      hysteresis    <= HYSTERESIS_RST;
      kind_q        <= '0;
      do_sweep      <= 1'b0;
      hit_q         <= 1'b0;
      removed       <= '0;
      slot_valid    <= '0;
      occ           <= '0;
      here_x        <= '0;
      here_y        <= '0;
      hit_counter   <= '0;
      miss_counter  <= '0;
      load_counter  <= '0;
      evict_counter <= '0;
      iss_on        <= 1'b0;
      iss_idx       <= '0;
      free_found    <= 1'b0;
      far_found     <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_MAX_ENTRIES: max_entries <= cfg.data[COUNT_BITS-1:0];
          REG_CACHE_RANGE: cache_range <= cfg.data[RANGE_BITS-1:0];
          REG_HYSTERESIS:  hysteresis  <= cfg.data[HYST_BITS-1:0];
          default: ;
        endcase
      end

      // In S_DONE the output register is reloaded below instead.
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_q     <= req.kind;
            hit_q      <= 1'b0;
            removed    <= '0;
            free_found <= 1'b0;
            far_found  <= 1'b0;
            do_sweep   <= 1'b0;
            case (req.kind)
              KIND_LOOKUP, KIND_INSERT, KIND_EVICT: begin
                pass    <= P_MATCH;
                iss_idx <= '0;
                iss_on  <= 1'b1;
                state   <= S_SCAN;
              end
              KIND_MOVE: begin
                // The new position takes effect before the scan, so the sweep
                // measures from it.
                here_x   <= req.tile_x;
                here_y   <= req.tile_y;
                do_sweep <= moved;
                pass     <= P_SWEEP;
                iss_idx  <= '0;
                iss_on   <= 1'b1;
                state    <= S_SCAN;
              end
              KIND_CLEAR: begin
                removed    <= occ;
                slot_valid <= '0;
                occ        <= '0;
                state      <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (iss_on) begin
            iss_idx <= iss_idx + IDX_BITS'(1);
            if (iss_last) begin
              iss_on <= 1'b0;
            end
          end

          if (d_tag.valid) begin
            case (pass)
              P_MATCH: begin
                // Tiles are unique in the table, so at most one slot matches.
                if (v_cur && d_match) begin
                  hit_q <= 1'b1;
                  if (kind_q == KIND_EVICT) begin
                    slot_valid[d_idx] <= 1'b0;
                    occ               <= occ - OCC_BITS'(1);
                    removed           <= OCC_BITS'(1);
                    evict_counter     <= evict_counter + TOTAL_BITS'(1);
                  end
                end
              end
              P_SWEEP: begin
                if (v_cur && d_match) begin
                  hit_q <= 1'b1;
                end
                if (v_cur && do_sweep && beyond) begin
                  slot_valid[d_idx] <= 1'b0;
                  occ               <= occ - OCC_BITS'(1);
                  removed           <= removed + OCC_BITS'(1);
                  evict_counter     <= evict_counter + TOTAL_BITS'(1);
                end
                // Lowest slot that is free once the sweep is through.
                if ((!v_cur || (do_sweep && beyond)) && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= d_idx;
                end
              end
              P_FAR: begin
                // Strictly farther only, so ties keep the lowest slot.
                if (v_cur && farther) begin
                  far_found <= 1'b1;
                  far_idx   <= d_idx;
                  far_dist  <= d_dist;
                end
              end
              default: ;
            endcase

            if (d_tag.last) begin
              state <= S_NEXT;
            end
          end
        end

        S_NEXT: begin
          case (pass)
            P_MATCH: begin
              if (kind_q == KIND_LOOKUP) begin
                if (hit_q) begin
                  hit_counter <= hit_counter + TOTAL_BITS'(1);
                end else begin
                  miss_counter <= miss_counter + TOTAL_BITS'(1);
                end
                state <= S_DONE;
              end else if (kind_q == KIND_INSERT && !hit_q) begin
                do_sweep <= 1'b1;
                pass     <= P_SWEEP;
                iss_idx  <= '0;
                iss_on   <= 1'b1;
                state    <= S_SCAN;
              end else begin
                state <= S_DONE;
              end
            end
            P_SWEEP: begin
              state <= (kind_q == KIND_INSERT) ? S_CHECK : S_DONE;
            end
            P_FAR: begin
              slot_valid[far_idx] <= 1'b0;
              occ                 <= occ - OCC_BITS'(1);
              removed             <= removed + OCC_BITS'(1);
              evict_counter       <= evict_counter + TOTAL_BITS'(1);
              if (!free_found || (far_idx < free_idx)) begin
                free_found <= 1'b1;
                free_idx   <= far_idx;
              end
              state <= S_CHECK;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        S_CHECK: begin
          if (need_far) begin
            far_found <= 1'b0;
            pass      <= P_FAR;
            iss_idx   <= '0;
            iss_on    <= 1'b1;
            state     <= S_SCAN;
          end else begin
            state <= S_STORE;
          end
        end

        S_STORE: begin
          // The coordinates go to the RAM in this cycle through ram_we.
          slot_valid[free_idx] <= 1'b1;
          occ                  <= occ + OCC_BITS'(1);
          load_counter         <= load_counter + TOTAL_BITS'(1);
          state                <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid       <= 1'b1;
            rsp_hit         <= hit_q;
            rsp_evicted_now <= COUNT_BITS'(removed);
            rsp_occupancy   <= COUNT_BITS'(occ);
            rsp_hit_total   <= hit_counter;
            rsp_miss_total  <= miss_counter;
            rsp_load_total  <= load_counter;
            rsp_evict_total <= evict_counter;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload of the scan results and of the request carries no reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      tx_q <= req.tile_x;
      ty_q <= req.tile_y;
    end
  end
endmodule

`default_nettype wire

// ----- hw/rtl/tcde_chk.sv -----
// ----------------------------------------------------------------------------
// tcde_chk
// Port-level checks of the tile cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcde_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [tcde_pkg::COUNT_BITS-1:0] evicted_now,
  input wire logic [tcde_pkg::TOTAL_BITS-1:0] hit_total,
  input wire logic [tcde_pkg::TOTAL_BITS-1:0] miss_total,
  input wire logic [tcde_pkg::TOTAL_BITS-1:0] evict_total
);
  import tcde_pkg::*;

  logic [1:0]            pending;
  logic [TOTAL_BITS-1:0] prev_lookups;
  logic [TOTAL_BITS-1:0] prev_evicts;
  logic [TOTAL_BITS-1:0] lookup_step;
  logic [TOTAL_BITS-1:0] evict_step;
  logic                  req_acc;
  logic                  rsp_acc;

  assign req_acc     = req_valid && req_ready;
  assign rsp_acc     = rsp_valid && rsp_ready;
  assign lookup_step = (hit_total + miss_total) - prev_lookups;
  assign evict_step  = evict_total - prev_evicts;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      prev_lookups <= '0;
      prev_evicts  <= '0;
    end else begin
      pending <= pending + {1'b0, req_acc} - {1'b0, rsp_acc};
      if (rsp_acc) begin
        prev_lookups <= hit_total + miss_total;
        prev_evicts  <= evict_total;
      end
    end
  end

  // A result is only ever shown for a request that was taken.
  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result shown with no request outstanding");

  // Accepting a request takes the request channel out of ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req_ready)
    else $error("request channel ready right after a transaction");

  // One transaction moves the lookup counters by at most one.
  a_lookup_step: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> (lookup_step == '0 || lookup_step == TOTAL_BITS'(1)))
    else $error("lookup counters moved by more than one");

  // The eviction total grows by the reported count, or not at all for a clear.
  a_evict_step: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> (evict_step == '0 || evict_step[COUNT_BITS-1:0] == evicted_now))
    else $error("eviction total disagrees with evicted_now");
endmodule

bind tile_cache_distance_eviction_unit tcde_chk u_tcde_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .evicted_now (rsp.evicted_now),
  .hit_total   (rsp.hit_total),
  .miss_total  (rsp.miss_total),
  .evict_total (rsp.evict_total)
);

`default_nettype wire

// ----- test/tcde_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcde_checker
// Watches the configuration, request and result channels of the tile cache,
// keeps its own copy of the tag table and compares every result transaction
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tcde_checker #(
  parameter int SLOTS      = 16,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  tcde_cfg_if  cfg,
  tcde_req_if  req,
  tcde_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);
  import tcde_pkg::*;

  typedef struct packed {
    logic                  hit;
    logic [COUNT_BITS-1:0] evicted_now;
    logic [COUNT_BITS-1:0] occupancy;
    logic [TOTAL_BITS-1:0] hit_total;
    logic [TOTAL_BITS-1:0] miss_total;
    logic [TOTAL_BITS-1:0] load_total;
    logic [TOTAL_BITS-1:0] evict_total;
  } table_result_t;

  logic                         slot_live [SLOTS];
  logic signed [COORD_BITS-1:0] slot_col  [SLOTS];
  logic signed [COORD_BITS-1:0] slot_row  [SLOTS];
  logic signed [COORD_BITS-1:0] cur_col;
  logic signed [COORD_BITS-1:0] cur_row;
  logic [TOTAL_BITS-1:0]        hits;
  logic [TOTAL_BITS-1:0]        misses;
  logic [TOTAL_BITS-1:0]        loads;
  logic [TOTAL_BITS-1:0]        evictions;
  logic [COUNT_BITS-1:0]        cap_reg;
  logic [RANGE_BITS-1:0]        range_reg;
  logic [HYST_BITS-1:0]         hyst_reg;

  table_result_t expected_results[$];
  int failures = 0;
  int waiting  = 0;

  assign fail_count = failures;
  assign pending    = waiting;

  function automatic longint unsigned distance_from_here(int i);
    longint a;
    longint b;
    longint unsigned dx;
    longint unsigned dy;
    a  = slot_col[i];
    b  = cur_col;
    dx = (a > b) ? a - b : b - a;
    a  = slot_row[i];
    b  = cur_row;
    dy = (a > b) ? a - b : b - a;
    return (dx > dy) ? dx : dy;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_live[i]) n++;
    return n;
  endfunction

  // Drops every entry beyond range plus hysteresis; the threshold is kept wide.
  function automatic int sweep_out_of_range();
    longint unsigned thr;
    int n;
    thr = longint'(range_reg) + longint'(hyst_reg);
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && distance_from_here(i) > thr) begin
        slot_live[i] = 1'b0;
        n++;
      end
    end
    evictions = evictions + TOTAL_BITS'(n);
    return n;
  endfunction

  function automatic table_result_t predict_request(logic [KIND_BITS-1:0] kind,
                                                    logic signed [COORD_BITS-1:0] x,
                                                    logic signed [COORD_BITS-1:0] y);
    table_result_t res;
    int found;
    int removed;
    int limit;
    int occ;
    int far;
    longint unsigned best;
    longint unsigned d;
    logic was_hit;
    logic moved;
    found   = -1;
    removed = 0;
    was_hit = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && slot_live[i] && slot_col[i] == x && slot_row[i] == y) found = i;

    case (kind)
      KIND_LOOKUP: begin
        was_hit = (found >= 0);
        if (was_hit) hits = hits + 1'b1;
        else misses = misses + 1'b1;
      end
      KIND_INSERT: begin
        was_hit = (found >= 0);
        if (!was_hit) begin
          limit   = (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
          removed = sweep_out_of_range();
          occ     = live_count();
          // Farthest entry goes first; a strict compare keeps the lowest slot on ties.
          while (occ > 0 && occ >= limit) begin
            far  = -1;
            best = 0;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_live[i]) begin
                d = distance_from_here(i);
                if (far < 0 || d > best) begin
                  far  = i;
                  best = d;
                end
              end
            end
            slot_live[far] = 1'b0;
            evictions = evictions + 1'b1;
            removed++;
            occ--;
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_live[i]) begin
              slot_live[i] = 1'b1;
              slot_col[i]  = x;
              slot_row[i]  = y;
              loads = loads + 1'b1;
              break;
            end
          end
        end
      end
      KIND_MOVE: begin
        moved   = (x != cur_col) || (y != cur_row);
        was_hit = (found >= 0);
        cur_col = x;
        cur_row = y;
        if (moved) removed = sweep_out_of_range();
      end
      KIND_EVICT: begin
        if (found >= 0) begin
          was_hit = 1'b1;
          slot_live[found] = 1'b0;
          evictions = evictions + 1'b1;
          removed = 1;
        end
      end
      KIND_CLEAR: begin
        removed = live_count();
        for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      end
      default: ;
    endcase

    res.hit         = was_hit;
    res.evicted_now = COUNT_BITS'(removed);
    res.occupancy   = COUNT_BITS'(live_count());
    res.hit_total   = hits;
    res.miss_total  = misses;
    res.load_total  = loads;
    res.evict_total = evictions;
    return res;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_col[i]  = '0;
        slot_row[i]  = '0;
      end
      cur_col   = '0;
      cur_row   = '0;
      hits      = '0;
      misses    = '0;
      loads     = '0;
      evictions = '0;
      cap_reg   = MAX_ENTRIES_RST;
      range_reg = CACHE_RANGE_RST;
      hyst_reg  = HYSTERESIS_RST;
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAX_ENTRIES: cap_reg   = cfg.data[COUNT_BITS-1:0];
          REG_CACHE_RANGE: range_reg = cfg.data[RANGE_BITS-1:0];
          REG_HYSTERESIS:  hyst_reg  = cfg.data[HYST_BITS-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with no request outstanding", $time);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", want.hit, rsp.hit);
          check_field("evicted_now", want.evicted_now, rsp.evicted_now);
          check_field("occupancy", want.occupancy, rsp.occupancy);
          check_field("hit_total", want.hit_total, rsp.hit_total);
          check_field("miss_total", want.miss_total, rsp.miss_total);
          check_field("load_total", want.load_total, rsp.load_total);
          check_field("evict_total", want.evict_total, rsp.evict_total);
        end
      end
      if (req.valid && req.ready)
        expected_results.insert(expected_results.size(),
                                predict_request(req.kind, req.tile_x, req.tile_y));
    end
    // Published through a nonblocking assignment so that the stimulus side never races with it.
    waiting <= expected_results.size();
  end

endmodule

// ----- test/tb_tile_cache_distance_eviction_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tile_cache_distance_eviction_unit
// Drives lookups, inserts, moves, evictions and clears into the tile cache
// under a series of table sizes, ranges and hysteresis values, and lets the
// checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb_tile_cache_distance_eviction_unit;
  import tcde_pkg::*;

  localparam int SLOTS           = 16;
  localparam int COORD_BITS      = 16;
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 10;
  // Longest quiet stretch of a correct run is the result hold-off plus one full
  // insert with every slot evicted by distance; the limit is several times that.
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_AFTER      = 500;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = SLOTS * 20;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES   = 8;
  localparam int POOL_DEPTH      = 24;

  // Kinds beyond clear are not decoded; the block must answer them unchanged.
  localparam logic [KIND_BITS-1:0]    KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_BITS-1:0]    KIND_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED    = 2'd3;

  logic clk;
  logic rst;
  logic burst;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   phases_run  = 0;
  int   kind_count[2**KIND_BITS];
  int   threshold;
  logic signed [COORD_BITS-1:0] here_col;
  logic signed [COORD_BITS-1:0] here_row;
  logic [2*COORD_BITS-1:0]      recent_tiles[$];

  // The table settings that the random phases walk through, extremes included.
  int phase_cap   [RANDOM_PHASES] = '{16, 1, 0,     31, 4, 8,   12, 2};
  int phase_range [RANDOM_PHASES] = '{2,  0, 65535, 3,  5, 0,   1,  65535};
  int phase_hyst  [RANDOM_PHASES] = '{1,  0, 255,   2,  0, 255, 1,  0};

  tcde_cfg_if                         cfg_if ();
  tcde_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
  tcde_rsp_if                         rsp_if ();

  tile_cache_distance_eviction_unit #(
    .SLOTS     (SLOTS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_if),
    .req(req_if),
    .rsp(rsp_if)
  );

  tcde_checker #(
    .SLOTS     (SLOTS),
    .COORD_BITS(COORD_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_if),
    .req       (req_if),
    .rsp       (rsp_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // The watchdog only looks for progress on any of the three channels, so a
  // hung handshake or a lost result both end here.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side. Each transaction is preceded by a random hold-off, unless the
  // phase runs back to back. Once, well into the run, ready is held low for a
  // long stretch while requests keep coming, so that the block backs up.
  initial begin
    int gap;
    int taken;
    taken = 0;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
      taken++;
      if (taken == HOLD_AFTER) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  function automatic int jitter(int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Sends one request. Valid is only dropped when a gap follows, so that a
  // back-to-back request never sees valid lowered and raised in one step.
  task automatic send_item(logic [KIND_BITS-1:0] kind, logic signed [COORD_BITS-1:0] x,
                           logic signed [COORD_BITS-1:0] y);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.kind   <= kind;
    req_if.tile_x <= x;
    req_if.tile_y <= y;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    kind_count[kind]++;
    if (kind == KIND_MOVE) begin
      here_col = x;
      here_row = y;
    end
    if (kind == KIND_INSERT) begin
      recent_tiles.insert(recent_tiles.size(), {x, y});
      if (recent_tiles.size() > POOL_DEPTH) void'(recent_tiles.pop_front());
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops requests and waits until every outstanding result has been taken.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Unused upper data bits are filled at random; the block must ignore them.
  task automatic configure(int cap, int rng, int hyst);
    settle();
    write_reg(REG_MAX_ENTRIES, CFG_DATA_BITS'(($urandom & 32'hFFE0) | (cap & 32'h1F)));
    write_reg(REG_CACHE_RANGE, CFG_DATA_BITS'(rng));
    write_reg(REG_HYSTERESIS, CFG_DATA_BITS'(($urandom & 32'hFF00) | (hyst & 32'hFF)));
    threshold = rng + hyst;
    phases_run++;
  endtask

  // Most tiles are ones inserted lately or lie close to the current tile, so
  // that hits, sweeps and farthest evictions all happen often. Some sit right
  // at the sweep threshold and a few are drawn over the whole coordinate space.
  task automatic pick_tile(output logic signed [COORD_BITS-1:0] x,
                           output logic signed [COORD_BITS-1:0] y);
    int r;
    int off;
    logic [2*COORD_BITS-1:0] t;
    r = $urandom_range(0, 99);
    if (r < 40 && recent_tiles.size() > 0) begin
      t = recent_tiles[$urandom_range(0, recent_tiles.size() - 1)];
      x = t[2*COORD_BITS-1:COORD_BITS];
      y = t[COORD_BITS-1:0];
    end else if (r < 75) begin
      x = COORD_BITS'(int'(here_col) + jitter(6));
      y = COORD_BITS'(int'(here_row) + jitter(6));
    end else if (r < 88) begin
      off = threshold + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) off = -off;
      if ($urandom_range(0, 1)) begin
        x = COORD_BITS'(int'(here_col) + off);
        y = COORD_BITS'(int'(here_row) + jitter(2));
      end else begin
        x = COORD_BITS'(int'(here_col) + jitter(2));
        y = COORD_BITS'(int'(here_row) + off);
      end
    end else begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
    end
  endtask

  task automatic run_random(int count);
    int r;
    logic [KIND_BITS-1:0] kind;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30 || r >= 98) kind = KIND_LOOKUP;
      else if (r < 70) kind = KIND_INSERT;
      else if (r < 80) kind = KIND_MOVE;
      else if (r < 95) kind = KIND_EVICT;
      else if (r < 96) kind = KIND_CLEAR;
      else kind = KIND_BITS'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      pick_tile(x, y);
      // Moves are mostly short steps or stay put, so the table is not wiped
      // on every change of position.
      if (kind == KIND_MOVE) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          x = here_col;
          y = here_row;
        end else if (r < 8) begin
          x = COORD_BITS'(int'(here_col) + jitter(2));
          y = COORD_BITS'(int'(here_row) + jitter(2));
        end
      end
      send_item(kind, x, y);
    end
  endtask

  initial begin
    rst           = 1'b1;
    burst         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.kind   = KIND_LOOKUP;
    req_if.tile_x = '0;
    req_if.tile_y = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_MAX_ENTRIES;
    cfg_if.data   = '0;
    here_col      = '0;
    here_row      = '0;
    threshold     = int'(CACHE_RANGE_RST) + int'(HYSTERESIS_RST);
    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset settings: a sweep threshold of three around the origin.
    send_item(KIND_LOOKUP, 16'sd0, 16'sd0);       // miss on the empty table
    send_item(KIND_INSERT, 16'sd0, 16'sd0);
    send_item(KIND_INSERT, 16'sd0, 16'sd0);       // already present, nothing moves
    send_item(KIND_LOOKUP, 16'sd0, 16'sd0);       // hit
    send_item(KIND_INSERT, 16'sd3, -16'sd3);
    send_item(KIND_INSERT, 16'sd4, 16'sd0);       // beyond the threshold but still stored
    send_item(KIND_MOVE, 16'sd0, 16'sd0);         // same tile, no sweep
    send_item(KIND_MOVE, 16'sd1, 16'sd0);         // distance exactly at the threshold is kept
    send_item(KIND_MOVE, -16'sd1, 16'sd0);        // two entries swept
    send_item(KIND_EVICT, 16'sd0, 16'sd0);
    send_item(KIND_EVICT, 16'sd9, 16'sd9);        // absent tile
    send_item(KIND_INSERT, 16'sh7FFF, 16'sh8000);
    send_item(KIND_MOVE, 16'sh8000, 16'sh7FFF);   // the largest possible distance
    send_item(KIND_INSERT, 16'sh7FFF, 16'sh8000);
    send_item(KIND_LOOKUP, 16'sh8000, 16'sh7FFF);
    send_item(KIND_CLEAR, 16'sd0, 16'sd0);
    send_item(KIND_SPARE_LO, 16'sh7FFF, 16'sh7FFF);
    send_item(KIND_SPARE_HI, 16'sh8000, 16'sh8000);

    // Widest threshold and a three-entry table: farthest eviction and its tie rule.
    settle();
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    configure(3, 65535, 255);
    send_item(KIND_INSERT, 16'sh7FFF, 16'sh8000); // 65535 away, kept
    send_item(KIND_MOVE, 16'sd0, 16'sd0);
    send_item(KIND_INSERT, 16'sd1, 16'sd0);
    send_item(KIND_INSERT, 16'sd0, -16'sd1);      // the table is now full
    send_item(KIND_INSERT, -16'sd1, 16'sd1);      // the far corner tile goes
    send_item(KIND_INSERT, 16'sd1, 16'sd1);       // three-way tie, lowest slot goes
    configure(0, 2, 1);
    send_item(KIND_INSERT, 16'sd2, 16'sd2);       // table emptied first
    configure(1, 2, 1);
    send_item(KIND_INSERT, 16'sd3, 16'sd3);
    configure(31, 2, 1);
    send_item(KIND_INSERT, 16'sd4, 16'sd4);       // treated as sixteen slots

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(phase_cap[p], phase_range[p], phase_hyst[p]);
      burst = (p % 3 == 2);
      run_random(ITEMS_PER_PHASE);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d lookups, %0d inserts, %0d moves, %0d evicts, %0d clears, %0d spare kinds",
             kind_count[KIND_LOOKUP], kind_count[KIND_INSERT], kind_count[KIND_MOVE],
             kind_count[KIND_EVICT], kind_count[KIND_CLEAR],
             kind_count[KIND_SPARE_LO] + kind_count[KIND_SPARE_LO + 3'd1] +
             kind_count[KIND_SPARE_HI]);
    $display("over %0d table settings, with one %0d-cycle stall of the result channel",
             phases_run, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tcde_pkg.sv
hw/rtl/tcde_if.sv
hw/rtl/tcde_ram.sv
hw/rtl/tcde_dist.sv
hw/rtl/tile_cache_distance_eviction_unit.sv
hw/rtl/tcde_chk.sv
test/tcde_checker.sv
test/tb_tile_cache_distance_eviction_unit.sv
